>>> rtl/core/ksfl_pkg.sv
// ----------------------------------------------------------------------------
// ksfl_pkg
// shared types and codes for the k-stacks shared free list unit
// ----------------------------------------------------------------------------
package ksfl_pkg;

    // field widths of the transactions
    localparam int MODE_W   = 2;
    localparam int SNO_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOP_W    = 7;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // empty top slot as seen on the result
    localparam logic [TOP_W-1:0] TOP_EMPTY = '1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SLOT
    } state_t;

    // which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_TOP,
        RES_OVERFLOW,
        RES_PUSH,
        RES_UNDERFLOW,
        RES_POP,
        RES_PEEK
    } res_kind_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      rd_top;
        logic      do_push;
        logic      do_pop;
        logic      emit;
        res_kind_t kind;
    } ksfl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              sn_ok;
        logic              top_nil;
        logic              free_nil;
        logic              out_free;
    } ksfl_stat_t;

endpackage

>>> rtl/core/k_stacks_shared_free_list_unit.sv
// ----------------------------------------------------------------------------
// k_stacks_shared_free_list_unit
// STACKS linked stacks sharing one store of SLOTS slots and one free list
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A transaction is accepted,
// then the stack head store (and the link at the free list head) is read
// through a register; a push, and a pop or peek of an empty stack, load the
// result from that read. A pop or peek of a non-empty stack then needs a
// second registered read of the slot data and link stores. The next
// transaction is accepted in the cycle after a result is loaded, while that
// result may still wait on m_tready; a result waits in its last step only if
// the previous one has not been taken. No clearing pass follows reset: a fill
// count stands in for the initial chaining of the link store, and head valid
// bits for the empty stacks, so the unit is ready right after reset.
// s_tuser carries the operation: 0 push, 1 pop, 2 peek. m_tuser carries the
// status: 0 ok, 1 overflow on push, 2 underflow on pop.
// ----------------------------------------------------------------------------
module k_stacks_shared_free_list_unit #(
    parameter int SLOTS  = 64,
    parameter int STACKS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // stack_no[2:0], value[34:3]
    input  logic [ksfl_pkg::MODE_W-1:0]   s_tuser,  // mode[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,  // data_out[31:0], top_slot[38:32]
    output logic [ksfl_pkg::STATUS_W-1:0] m_tuser   // status[1:0]
);
    import ksfl_pkg::*;

    ksfl_cmd_t  cmd;
    ksfl_stat_t stat;

    // sequencer
    ksfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores and result register
    ksfl_dpath #(
        .SLOTS  (SLOTS),
        .STACKS (STACKS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> rtl/core/ksfl_ctrl.sv
// ----------------------------------------------------------------------------
// ksfl_ctrl
// sequencer: accepts one transaction, steps it through head and slot reads
// ----------------------------------------------------------------------------
module ksfl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ksfl_pkg::ksfl_stat_t stat,
    output ksfl_pkg::ksfl_cmd_t  cmd
);
    import ksfl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.kind    = RES_TOP;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (!stat.sn_ok) begin
                    cmd.kind = RES_TOP;
                    cmd.emit = stat.out_free;
                end else begin
                    case (stat.mode)
                        MODE_PUSH: begin
                            if (stat.free_nil) begin
                                cmd.kind = RES_OVERFLOW;
                                cmd.emit = stat.out_free;
                            end else begin
                                cmd.kind    = RES_PUSH;
                                cmd.emit    = stat.out_free;
                                cmd.do_push = stat.out_free;
                            end
                        end
                        MODE_POP: begin
                            if (stat.top_nil) begin
                                cmd.kind = RES_UNDERFLOW;
                                cmd.emit = stat.out_free;
                            end else begin
                                cmd.rd_top = 1'b1;
                            end
                        end
                        MODE_PEEK: begin
                            if (stat.top_nil) begin
                                cmd.kind = RES_TOP;
                                cmd.emit = stat.out_free;
                            end else begin
                                cmd.rd_top = 1'b1;
                            end
                        end
                        default: begin
                            cmd.kind = RES_TOP;
                            cmd.emit = stat.out_free;
                        end
                    endcase
                end
                if (cmd.rd_top) begin
                    state_next = ST_SLOT;
                end else if (cmd.emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT: begin
                if (stat.mode == MODE_POP) begin
                    cmd.kind   = RES_POP;
                    cmd.do_pop = stat.out_free;
                end else begin
                    cmd.kind = RES_PEEK;
                end
                cmd.emit = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ksfl_dpath.sv
// ----------------------------------------------------------------------------
// ksfl_dpath
// slot, link and head stores, free list head, fill count and output register
// ----------------------------------------------------------------------------
module ksfl_dpath #(
    parameter int SLOTS  = 64,
    parameter int STACKS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [39:0]                 s_tdata,
    input  logic [ksfl_pkg::MODE_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,
    output logic [ksfl_pkg::STATUS_W-1:0] m_tuser,
    input  ksfl_pkg::ksfl_cmd_t         cmd,
    output ksfl_pkg::ksfl_stat_t        stat
);
    import ksfl_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int SN_W   = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam logic [LINK_W-1:0] NIL = '1;

    // encode a link for the result: empty is all ones, else low bits of the index
    function automatic logic [TOP_W-1:0] enc_top(input logic [LINK_W-1:0] v);
        logic [IDX_W+TOP_W-1:0] w;
        w = {{TOP_W{1'b0}}, v[IDX_W-1:0]};
        return v[LINK_W-1] ? TOP_EMPTY : w[TOP_W-1:0];
    endfunction

    // input fields
    logic [SNO_W-1:0]   in_sno;
    logic [VALUE_W-1:0] in_value;
    logic [SN_W+SNO_W-1:0] in_sn_wide;
    logic [SN_W-1:0]    in_saddr;
    logic               in_sn_ok;

    assign in_sno     = s_tdata[SNO_W-1:0];
    assign in_value   = s_tdata[SNO_W+VALUE_W-1:SNO_W];
    assign in_sn_wide = {{SN_W{1'b0}}, in_sno};
    assign in_saddr   = in_sn_wide[SN_W-1:0];
    assign in_sn_ok   = (32'(in_sno) < STACKS);

    // captured transaction
    logic [MODE_W-1:0]  mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [SN_W-1:0]    saddr_reg;
    logic               sn_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tuser;
            value_reg <= in_value;
            saddr_reg <= in_saddr;
            sn_ok_reg <= in_sn_ok;
        end
    end

    // free list head and fill count (slots at or above the count are untouched)
    logic [LINK_W-1:0] free_head_reg;
    logic [CNT_W-1:0]  fill_reg;

    // head store with valid bits
    logic [LINK_W-1:0] head_mem [STACKS];
    logic [STACKS-1:0] head_vld_reg;
    logic [LINK_W-1:0] head_rd_reg;
    logic              head_rdv_reg;
    logic [LINK_W-1:0] top_q;

    assign top_q = head_rdv_reg ? head_rd_reg : NIL;

    // link and data stores
    logic [LINK_W-1:0]  link_mem [SLOTS];
    logic [VALUE_W-1:0] data_mem [SLOTS];
    logic [LINK_W-1:0]  link_rd_reg;
    logic               link_virt_reg;
    logic [LINK_W-1:0]  link_vval_reg;
    logic [VALUE_W-1:0] data_rd_reg;
    logic [LINK_W-1:0]  link_q;

    assign link_q = link_virt_reg ? link_vval_reg : link_rd_reg;

    // link read address and the value an untouched slot holds
    logic [IDX_W-1:0]  lrd_addr;
    logic [CNT_W-1:0]  lrd_ext;
    logic [CNT_W-1:0]  lrd_plus;
    logic [LINK_W-1:0] lrd_virt_val;

    assign lrd_addr     = cmd.capture ? free_head_reg[IDX_W-1:0] : top_q[IDX_W-1:0];
    assign lrd_ext      = {1'b0, lrd_addr};
    assign lrd_plus     = lrd_ext + CNT_W'(1);
    assign lrd_virt_val = (lrd_plus < CNT_W'(SLOTS)) ? {1'b0, lrd_plus[IDX_W-1:0]} : NIL;

    // push and pop targets
    logic [IDX_W-1:0] fh_idx;
    logic [IDX_W-1:0] top_idx;
    logic [CNT_W-1:0] fh_ext;

    assign fh_idx  = free_head_reg[IDX_W-1:0];
    assign top_idx = top_q[IDX_W-1:0];
    assign fh_ext  = {1'b0, fh_idx};

    // control registers: free head, fill count, head valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            head_vld_reg  <= '0;
        end else begin
            if (cmd.do_push) begin
                free_head_reg          <= link_q;
                head_vld_reg[saddr_reg] <= 1'b1;
                if (fh_ext >= fill_reg) begin
                    fill_reg <= fh_ext + CNT_W'(1);
                end
            end else if (cmd.do_pop) begin
                free_head_reg          <= top_q;
                head_vld_reg[saddr_reg] <= 1'b1;
            end
        end
    end

    // head store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            head_mem[saddr_reg] <= free_head_reg;
        end else if (cmd.do_pop) begin
            head_mem[saddr_reg] <= link_q;
        end
        if (cmd.capture) begin
            head_rd_reg  <= head_mem[in_saddr];
            head_rdv_reg <= in_sn_ok && head_vld_reg[in_saddr];
        end
    end

    // link store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            link_mem[fh_idx] <= top_q;
        end else if (cmd.do_pop) begin
            link_mem[top_idx] <= free_head_reg;
        end
        if (cmd.capture || cmd.rd_top) begin
            link_rd_reg   <= link_mem[lrd_addr];
            link_virt_reg <= (lrd_ext >= fill_reg);
            link_vval_reg <= lrd_virt_val;
        end
    end

    // data store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            data_mem[fh_idx] <= value_reg;
        end
        if (cmd.rd_top) begin
            data_rd_reg <= data_mem[top_idx];
        end
    end

    // result selection
    logic [STATUS_W-1:0] res_status;
    logic [VALUE_W-1:0]  res_data;
    logic [TOP_W-1:0]    res_top;

    always_comb begin
        res_status = STATUS_OK;
        res_data   = '0;
        res_top    = enc_top(top_q);
        case (cmd.kind)
            RES_TOP: begin
                res_top = sn_ok_reg ? enc_top(top_q) : TOP_EMPTY;
            end
            RES_OVERFLOW: begin
                res_status = STATUS_OVERFLOW;
            end
            RES_PUSH: begin
                res_top = enc_top(free_head_reg);
            end
            RES_UNDERFLOW: begin
                res_status = STATUS_UNDERFLOW;
                res_top    = TOP_EMPTY;
            end
            RES_POP: begin
                res_data = data_rd_reg;
                res_top  = enc_top(link_q);
            end
            RES_PEEK: begin
                res_data = data_rd_reg;
            end
            default: begin
                res_top = TOP_EMPTY;
            end
        endcase
    end

    // output register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic [VALUE_W-1:0]  data_out_reg;
    logic [TOP_W-1:0]    top_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_out_reg <= res_status;
            data_out_reg   <= res_data;
            top_out_reg    <= res_top;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = {1'b0, top_out_reg, data_out_reg};

    // status to the controller
    assign stat.mode     = mode_reg;
    assign stat.sn_ok    = sn_ok_reg;
    assign stat.top_nil  = top_q[LINK_W-1];
    assign stat.free_nil = free_head_reg[LINK_W-1];
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule
